FILE: src/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache core.
package salc_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_IFETCH = 2'd3;

    localparam logic [1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic is_modify;
        logic is_ifetch;
        logic clr_last;
    } t_status;

endpackage

FILE: src/salc_ctrl.sv
// Controller: sequences set read, update and result delivery per request.
module salc_ctrl
    import salc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output logic    o_last,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_oval, n_oval;
    logic   r_olast, n_olast;
    logic   out_free;

    // output register can take a new result when empty or being drained
    assign out_free = !r_oval || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_second <= 1'b0;
            r_oval   <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_oval   <= n_oval;
            r_olast  <= n_olast;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_oval   = r_oval && i_stall;
        n_olast  = r_olast;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_second = 1'b0;
                    n_state  = ST_READ;
                end
            end
            ST_READ: begin
                if (i_status.is_ifetch) n_state = ST_IDLE;
                else n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_olast = !i_status.is_modify || r_second;
                    if (i_status.is_modify && !r_second) begin
                        n_second = 1'b1;
                        n_state  = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_stall  = 1'b1;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            ST_READ:   o_cmd.read = !i_status.is_ifetch;
            ST_UPDATE: begin
                o_cmd.update   = out_free;
                o_cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    assign o_valid = r_oval;
    assign o_last  = r_olast;

endmodule

FILE: src/salc_dp.sv
// Datapath: set memory, lookup, LRU update and saturating counters.
module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 6,
    parameter int MAX_WAYS       = 8,
    parameter int ADDR_WIDTH     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [5:0]            i_cfg_data,
    input  logic [1:0]            i_operation,
    input  logic [ADDR_WIDTH-1:0] i_address,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic [31:0]           o_total_hits,
    output logic [31:0]           o_total_misses,
    output logic [31:0]           o_total_evictions
);

    localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SB = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int NSETS = 1 << MAX_INDEX_BITS;
    localparam int RB = WB;
    localparam logic [RB-1:0] RMAX = RB'(MAX_WAYS - 1);
    localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

    typedef logic [ADDR_WIDTH-1:0] t_tag;
    typedef struct packed {
        logic [MAX_WAYS-1:0]        valid;
        logic [MAX_WAYS-1:0][RB-1:0] rank;
    } t_meta;

    // Tags per set; contents undefined until written.
    t_tag  r_tags [NSETS][MAX_WAYS];
    t_tag  r_rtag [MAX_WAYS];
    // Valid and rank per set, cleared one set per cycle after reset.
    t_meta r_meta [NSETS];
    t_meta r_rmeta;

    logic [2:0] r_ib;
    logic [5:0] r_ob;
    logic [3:0] r_ways;
    logic [1:0] r_op;
    logic [SB-1:0] r_set;
    logic [SB-1:0] r_clr_idx;
    t_tag       r_tag;
    logic [31:0] r_hits, r_miss, r_evs;
    logic       r_hit, r_ev;

    logic [3:0]  ib_eff;
    logic [4:0]  n_eff;
    logic [6:0]  sh;
    logic [SB-1:0] set_c;
    t_tag        tag_c, shifted;

    always_comb begin
        ib_eff = (32'(r_ib) > MAX_INDEX_BITS) ? 4'(MAX_INDEX_BITS) : {1'b0, r_ib};
        n_eff  = (r_ways == 4'd0) ? 5'd1 : {1'b0, r_ways};
        if (32'(n_eff) > MAX_WAYS) n_eff = 5'(MAX_WAYS);
        sh      = 7'(r_ob) + 7'(ib_eff);
        shifted = i_address >> r_ob;
        set_c   = SB'(shifted & t_tag'((64'd1 << ib_eff) - 64'd1));
        tag_c   = (sh >= 7'(ADDR_WIDTH)) ? '0 : t_tag'(i_address >> sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib   <= '0;
            r_ob   <= '0;
            r_ways <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_INDEX_BITS:  r_ib   <= i_cfg_data[2:0];
                CFG_OFFSET_BITS: r_ob   <= i_cfg_data;
                CFG_WAYS:        r_ways <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_set <= set_c;
            r_tag <= tag_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            for (int w = 0; w < MAX_WAYS; w++) r_rtag[w] <= r_tags[r_set][w];
        end
    end

    // Lookup and LRU update on the registered set.
    logic          found, have_free, evict;
    logic [WB-1:0] victim, hw, fw, lw;
    logic [RB-1:0] cut;
    logic [4:0]    cutw;
    t_meta         n_meta;

    always_comb begin
        found = 1'b0; have_free = 1'b0; hw = '0; fw = '0; lw = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (32'(w) < 32'(n_eff)) begin
                if (r_rmeta.valid[w] && r_rtag[w] == r_tag) begin
                    found = 1'b1; hw = WB'(w);
                end
                if (!r_rmeta.valid[w]) begin
                    have_free = 1'b1; fw = WB'(w);
                end
            end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (32'(w) < 32'(n_eff) && r_rmeta.rank[w] > r_rmeta.rank[lw]) lw = WB'(w);
        end
        evict  = !found && !have_free;
        victim = found ? hw : (have_free ? fw : lw);
        cut    = r_rmeta.rank[victim];
        cutw   = (found || evict) ? 5'(cut) : 5'(MAX_WAYS);
        n_meta = r_rmeta;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (32'(v) < 32'(n_eff) && WB'(v) != victim && r_rmeta.valid[v]
                && 5'(r_rmeta.rank[v]) < cutw && r_rmeta.rank[v] < RMAX)
                n_meta.rank[v] = r_rmeta.rank[v] + 1'b1;
        end
        n_meta.rank[victim]  = '0;
        n_meta.valid[victim] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_idx <= '0;
        else if (i_cmd.clear) r_clr_idx <= r_clr_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_meta[r_clr_idx] <= '0;
        end else if (i_cmd.update) begin
            r_meta[r_set] <= n_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) r_rmeta <= r_meta[r_set];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !found) r_tags[r_set][victim] <= r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0; r_miss <= '0; r_evs <= '0;
        end else if (i_cmd.update) begin
            if (found && r_hits != CMAX) r_hits <= r_hits + 32'd1;
            if (!found && r_miss != CMAX) r_miss <= r_miss + 32'd1;
            if (evict && r_evs != CMAX) r_evs <= r_evs + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_hit <= found;
            r_ev  <= evict;
        end
    end

    assign o_status.is_modify = (r_op == OP_MODIFY);
    assign o_status.is_ifetch = (r_op == OP_IFETCH);
    assign o_status.clr_last  = (r_clr_idx == SB'(NSETS - 1));
    assign o_hit             = r_hit;
    assign o_evicted         = r_ev;
    assign o_total_hits      = r_hits;
    assign o_total_misses    = r_miss;
    assign o_total_evictions = r_evs;

endmodule

FILE: src/set_assoc_lru_cache_sim_core.sv
// Top level of the set-associative LRU cache core.
// Tag-only cache model: each request carries an operation and an address and yields one
// result per access (modify yields two, instruction fetch none). A request is captured at
// acceptance, its set is read in the next cycle and then updated once the output register
// is free, when the result is loaded into the output register and the totals are counted.
// The input stays stalled until the request's last access is done, as the single-ported
// set memory is read then written per access; the update waits while the output register
// holds a stalled result. After reset the valid and rank state is cleared one set per
// cycle, all 2^MAX_INDEX_BITS sets, with the input stalled; tags are undefined until filled.
module set_assoc_lru_cache_sim_core
    import salc_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 6,
    parameter int MAX_WAYS       = 8,
    parameter int ADDR_WIDTH     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [5:0]            i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_operation,
    input  logic [ADDR_WIDTH-1:0] i_address,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic                  o_last,
    output logic [31:0]           o_total_hits,
    output logic [31:0]           o_total_misses,
    output logic [31:0]           o_total_evictions
);

    t_cmd    cmd;
    t_status status;

    salc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_last(o_last),
        .i_status(status), .o_cmd(cmd)
    );

    salc_dp #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data), .i_operation(i_operation), .i_address(i_address),
        .i_cmd(cmd), .o_status(status), .o_hit(o_hit), .o_evicted(o_evicted),
        .o_total_hits(o_total_hits), .o_total_misses(o_total_misses),
        .o_total_evictions(o_total_evictions)
    );

endmodule

FILE: src/salc_checker.sv
// Port-level checker for the cache core, bound to the top level.
module salc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic        o_evicted,
    input logic [31:0] o_total_misses
);

    a_no_result_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result pending right after reset");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted)) else $error("hit with eviction");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_misses))
        else $error("stalled result changed");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("back-to-back accept");

endmodule

bind set_assoc_lru_cache_sim_core salc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit), .o_evicted(o_evicted),
    .o_total_misses(o_total_misses)
);
